### rtl/core/tbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_pkg: shared constants for the texture bilinear sampler
// Register indexes, command codes and field widths.
// ----------------------------------------------------------------------------
package tbs_pkg;

   localparam int MAX_SIDE_DEF  = 128;
   localparam int FRAC_BITS_DEF = 16;

   localparam int COORD_W = 17;
   localparam int CHAN_W  = 8;
   localparam int TEXEL_W = 3 * CHAN_W;
   localparam int DIM_W   = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TEX_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TEX_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLE_MODE = 2'd2;

   // command codes
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic MODE_NEAREST  = 1'b0;
   localparam logic MODE_BILINEAR = 1'b1;

endpackage

### rtl/core/texture_bilinear_sampler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_bilinear_sampler: RGB texture store with nearest/bilinear sampling
//
// Request channel: a request is taken when start is high and busy is low;
// busy is always low, so one request may enter every cycle. req_cmd selects
// a texel write (no response) or a sample at req_u_coord/req_v_coord.
// Response channel: rsp_valid pulses for one cycle with rsp_red/green/blue;
// the receiver cannot stall, so no backpressure exists.
// Pipeline: a sample passes two front stages of scale and clamp, one bank
// read, and a horizontal and a vertical blend stage before its response is
// on the ports. Throughput is one request per cycle, set by the four texel
// store copies that read all neighbors in the same cycle.
// A write is visible to any sample accepted after it.
// CSR channel: csr_ready is always high; write tex_width, tex_height and
// sample_mode only while no request is in flight.
// Reset: synchronous; clears control state and loads 64x64 bilinear.
// The texel store has no reset: read only texels already written.
// ----------------------------------------------------------------------------
module texture_bilinear_sampler #(
   parameter int MAX_SIDE  = tbs_pkg::MAX_SIDE_DEF,
   parameter int FRAC_BITS = tbs_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_cmd,
   input  logic [6:0]                    req_write_col,
   input  logic [6:0]                    req_write_row,
   input  logic [7:0]                    req_pixel_red,
   input  logic [7:0]                    req_pixel_green,
   input  logic [7:0]                    req_pixel_blue,
   input  logic [16:0]                   req_u_coord,
   input  logic [16:0]                   req_v_coord,
   output logic                          rsp_valid,
   output logic [7:0]                    rsp_red,
   output logic [7:0]                    rsp_green,
   output logic [7:0]                    rsp_blue,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tbs_pkg::CSR_DAT_W-1:0] csr_data
);
   localparam int AW = $clog2(MAX_SIDE);

   // configuration registers
   logic [7:0] width_ff, height_ff;
   logic       mode_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 8'd64;
         height_ff <= 8'd64;
         mode_ff   <= tbs_pkg::MODE_BILINEAR;
      end else if (csr_valid) begin
         case (csr_index)
            tbs_pkg::REG_TEX_WIDTH:   width_ff  <= csr_data;
            tbs_pkg::REG_TEX_HEIGHT:  height_ff <= csr_data;
            tbs_pkg::REG_SAMPLE_MODE: mode_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end
   assign csr_ready = 1'b1;
   assign busy = 1'b0;

   logic                        f_valid, f_cmd, f_wok;
   logic [AW-1:0]               f_wcol, f_wrow, f_x0, f_x1, f_y0, f_y1;
   logic [tbs_pkg::TEXEL_W-1:0] f_texel, b_texel;
   logic [FRAC_BITS-1:0]        f_fx, f_fy;

   tbs_front #(.MAX_SIDE(MAX_SIDE), .FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(start && !busy), .in_cmd(req_cmd),
      .in_col(req_write_col), .in_row(req_write_row),
      .in_texel({req_pixel_red, req_pixel_green, req_pixel_blue}),
      .in_u(req_u_coord), .in_v(req_v_coord),
      .cfg_width(width_ff), .cfg_height(height_ff), .cfg_mode(mode_ff),
      .out_valid(f_valid), .out_cmd(f_cmd), .out_wr_ok(f_wok),
      .out_wcol(f_wcol), .out_wrow(f_wrow), .out_texel(f_texel),
      .out_x0(f_x0), .out_x1(f_x1), .out_y0(f_y0), .out_y1(f_y1),
      .out_fx(f_fx), .out_fy(f_fy)
   );

   tbs_back #(.MAX_SIDE(MAX_SIDE), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_cmd(f_cmd), .in_wr_ok(f_wok),
      .in_wcol(f_wcol), .in_wrow(f_wrow), .in_texel(f_texel),
      .in_x0(f_x0), .in_x1(f_x1), .in_y0(f_y0), .in_y1(f_y1),
      .in_fx(f_fx), .in_fy(f_fy),
      .out_valid(rsp_valid), .out_texel(b_texel)
   );

   assign rsp_red   = b_texel[23:16];
   assign rsp_green = b_texel[15:8];
   assign rsp_blue  = b_texel[7:0];
endmodule

### rtl/core/tbs_lerp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_lerp: registered per-channel blend of two texels
// Each channel computes a + floor((b-a)*f / 2^FRAC_BITS), one register stage.
// ----------------------------------------------------------------------------
module tbs_lerp #(
   parameter int FRAC_BITS = tbs_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic [tbs_pkg::TEXEL_W-1:0] a,
   input  logic [tbs_pkg::TEXEL_W-1:0] b,
   input  logic [FRAC_BITS-1:0]        frac,
   output logic [tbs_pkg::TEXEL_W-1:0] q_ff
);
   localparam int CW = tbs_pkg::CHAN_W;
   localparam int PW = CW + 1 + FRAC_BITS + 1;

   logic [tbs_pkg::TEXEL_W-1:0] q_in;

   // signed difference times fraction, arithmetic shift floors the result
   always_comb begin
      logic signed [CW:0]   diff;
      logic signed [PW-1:0] prod;
      logic signed [PW-1:0] sh;
      q_in = '0;
      for (int c = 0; c < 3; c++) begin
         diff = $signed({1'b0, b[c*CW +: CW]}) - $signed({1'b0, a[c*CW +: CW]});
         prod = PW'(diff) * $signed({1'b0, frac});
         sh   = prod >>> FRAC_BITS;
         q_in[c*CW +: CW] = a[c*CW +: CW] + sh[CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end
endmodule

### rtl/core/tbs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_front: request classification and texel addressing
// Saturates coordinates, scales them by the size (less one if bilinear) in a
// registered multiply, then clamps to corner/neighbor columns, rows, fractions.
// ----------------------------------------------------------------------------
module tbs_front #(
   parameter int MAX_SIDE  = tbs_pkg::MAX_SIDE_DEF,
   parameter int FRAC_BITS = tbs_pkg::FRAC_BITS_DEF,
   localparam int AW = $clog2(MAX_SIDE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_cmd,
   input  logic [6:0]                  in_col,
   input  logic [6:0]                  in_row,
   input  logic [tbs_pkg::TEXEL_W-1:0] in_texel,
   input  logic [16:0]                 in_u,
   input  logic [16:0]                 in_v,
   input  logic [tbs_pkg::DIM_W-1:0]   cfg_width,
   input  logic [tbs_pkg::DIM_W-1:0]   cfg_height,
   input  logic                        cfg_mode,
   // to back end
   output logic                        out_valid,
   output logic                        out_cmd,
   output logic                        out_wr_ok,
   output logic [AW-1:0]               out_wcol,
   output logic [AW-1:0]               out_wrow,
   output logic [tbs_pkg::TEXEL_W-1:0] out_texel,
   output logic [AW-1:0]               out_x0,
   output logic [AW-1:0]               out_x1,
   output logic [AW-1:0]               out_y0,
   output logic [AW-1:0]               out_y1,
   output logic [FRAC_BITS-1:0]        out_fx,
   output logic [FRAC_BITS-1:0]        out_fy
);
   localparam int SW = $clog2(MAX_SIDE + 1);
   localparam int PW = 17 + SW;

   // clamped dimensions
   logic [SW-1:0] w_c, h_c;
   always_comb begin
      if (cfg_width == '0) w_c = SW'(1);
      else if ({24'd0, cfg_width} > 32'(MAX_SIDE)) w_c = SW'(MAX_SIDE);
      else w_c = SW'(cfg_width);
      if (cfg_height == '0) h_c = SW'(1);
      else if ({24'd0, cfg_height} > 32'(MAX_SIDE)) h_c = SW'(MAX_SIDE);
      else h_c = SW'(cfg_height);
   end

   logic [16:0] u_s, v_s;
   assign u_s = (in_u > 17'h10000) ? 17'h10000 : in_u;
   assign v_s = (in_v > 17'h10000) ? 17'h10000 : in_v;

   logic [SW-1:0] mx, my;
   assign mx = (cfg_mode == tbs_pkg::MODE_NEAREST) ? w_c : w_c - SW'(1);
   assign my = (cfg_mode == tbs_pkg::MODE_NEAREST) ? h_c : h_c - SW'(1);

   // stage 1: scale
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_cmd_ff, s1_mode_ff, s1_wok_ff;
   logic [AW-1:0]               s1_wcol_ff, s1_wrow_ff;
   logic [tbs_pkg::TEXEL_W-1:0] s1_texel_ff;
   logic [PW-1:0]               s1_sx_ff, s1_sy_ff;
   logic [SW-1:0]               s1_wm1_ff, s1_hm1_ff;

   assign s1_valid_in = in_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      s1_cmd_ff   <= in_cmd;
      s1_mode_ff  <= cfg_mode;
      s1_wok_ff   <= (32'(in_col) < 32'(MAX_SIDE)) && (32'(in_row) < 32'(MAX_SIDE));
      s1_wcol_ff  <= AW'(in_col);
      s1_wrow_ff  <= AW'(in_row);
      s1_texel_ff <= in_texel;
      s1_sx_ff    <= PW'(u_s) * PW'(mx);
      s1_sy_ff    <= PW'(v_s) * PW'(my);
      s1_wm1_ff   <= w_c - SW'(1);
      s1_hm1_ff   <= h_c - SW'(1);
   end

   // stage 2: clamp and neighbor
   logic [PW-17:0] xi, yi;
   logic [SW-1:0]  x0, y0, x1, y1;
   logic [15:0]    fx16, fy16;
   always_comb begin
      xi = s1_sx_ff[PW-1:16];
      yi = s1_sy_ff[PW-1:16];
      x0 = (32'(xi) > 32'(s1_wm1_ff)) ? s1_wm1_ff : SW'(xi);
      y0 = (32'(yi) > 32'(s1_hm1_ff)) ? s1_hm1_ff : SW'(yi);
      x1 = (x0 >= s1_wm1_ff) ? s1_wm1_ff : x0 + SW'(1);
      y1 = (y0 >= s1_hm1_ff) ? s1_hm1_ff : y0 + SW'(1);
      fx16 = s1_sx_ff[15:0];
      fy16 = s1_sy_ff[15:0];
      if (s1_mode_ff == tbs_pkg::MODE_NEAREST) begin
         x1 = x0;
         y1 = y0;
         fx16 = '0;
         fy16 = '0;
      end
   end

   function automatic logic [FRAC_BITS-1:0] scale_f(input logic [15:0] f);
      logic [FRAC_BITS+15:0] t;
      t = {{FRAC_BITS{1'b0}}, f} << FRAC_BITS;
      return t[FRAC_BITS+15:16];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid <= 1'b0;
      end else begin
         out_valid <= s1_valid_ff;
      end
      out_cmd   <= s1_cmd_ff;
      out_wr_ok <= s1_wok_ff;
      out_wcol  <= s1_wcol_ff;
      out_wrow  <= s1_wrow_ff;
      out_texel <= s1_texel_ff;
      out_x0    <= AW'(x0);
      out_x1    <= AW'(x1);
      out_y0    <= AW'(y0);
      out_y1    <= AW'(y1);
      out_fx    <= scale_f(fx16);
      out_fy    <= scale_f(fy16);
   end
endmodule

### rtl/core/tbs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbs_back: texel store copies and blend pipeline
// Four full copies of the texture, each with its own read port, so that the
// four neighbors read in the same cycle; then horizontal and vertical blends.
// ----------------------------------------------------------------------------
module tbs_back #(
   parameter int MAX_SIDE  = tbs_pkg::MAX_SIDE_DEF,
   parameter int FRAC_BITS = tbs_pkg::FRAC_BITS_DEF,
   localparam int AW = $clog2(MAX_SIDE)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  logic                        in_cmd,
   input  logic                        in_wr_ok,
   input  logic [AW-1:0]               in_wcol,
   input  logic [AW-1:0]               in_wrow,
   input  logic [tbs_pkg::TEXEL_W-1:0] in_texel,
   input  logic [AW-1:0]               in_x0,
   input  logic [AW-1:0]               in_x1,
   input  logic [AW-1:0]               in_y0,
   input  logic [AW-1:0]               in_y1,
   input  logic [FRAC_BITS-1:0]        in_fx,
   input  logic [FRAC_BITS-1:0]        in_fy,
   output logic                        out_valid,
   output logic [tbs_pkg::TEXEL_W-1:0] out_texel
);
   localparam int TW = tbs_pkg::TEXEL_W;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;

   // four full copies, one read port each
   logic [TW-1:0] mem00 [DEPTH];
   logic [TW-1:0] mem01 [DEPTH];
   logic [TW-1:0] mem10 [DEPTH];
   logic [TW-1:0] mem11 [DEPTH];

   logic          wr_en;
   logic [2*AW-1:0] waddr;
   assign wr_en = in_valid && (in_cmd == tbs_pkg::CMD_WRITE) && in_wr_ok;
   assign waddr = {in_wrow, in_wcol};

   logic [TW-1:0] t00_ff, t01_ff, t10_ff, t11_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem00[waddr] <= in_texel;
         mem01[waddr] <= in_texel;
         mem10[waddr] <= in_texel;
         mem11[waddr] <= in_texel;
      end
      t00_ff <= mem00[{in_y0, in_x0}];
      t01_ff <= mem01[{in_y0, in_x1}];
      t10_ff <= mem10[{in_y1, in_x0}];
      t11_ff <= mem11[{in_y1, in_x1}];
   end

   // pipeline control: read, horizontal, vertical
   logic                 r_valid_ff, h_valid_ff, v_valid_ff;
   logic [FRAC_BITS-1:0] r_fx_ff, r_fy_ff, h_fy_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         v_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= in_valid && (in_cmd == tbs_pkg::CMD_SAMPLE);
         h_valid_ff <= r_valid_ff;
         v_valid_ff <= h_valid_ff;
      end
      r_fx_ff <= in_fx;
      r_fy_ff <= in_fy;
      h_fy_ff <= r_fy_ff;
   end

   logic [TW-1:0] top_ff, bot_ff;

   tbs_lerp #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clock(clock), .a(t00_ff), .b(t01_ff), .frac(r_fx_ff), .q_ff(top_ff)
   );
   tbs_lerp #(.FRAC_BITS(FRAC_BITS)) u_bot (
      .clock(clock), .a(t10_ff), .b(t11_ff), .frac(r_fx_ff), .q_ff(bot_ff)
   );
   tbs_lerp #(.FRAC_BITS(FRAC_BITS)) u_ver (
      .clock(clock), .a(top_ff), .b(bot_ff), .frac(h_fy_ff), .q_ff(out_texel)
   );

   assign out_valid = v_valid_ff;
endmodule
